// ----- hw/rtl/swli_pkg.sv -----
// Shared constants, codes and types for the lazy-increment stack.
package swli_pkg;

    localparam int DEPTH  = 1024;                   // entries in each store
    localparam int AW     = $clog2(DEPTH);          // store address width
    localparam int DEP_W  = $clog2(DEPTH + 1);      // depth counter, holds DEPTH itself
    localparam int DW     = 32;                     // value width
    localparam int CNT_W  = 11;                     // count and capacity width
    localparam int MODE_W = 2;
    localparam int CMP_W  = (DEP_W > CNT_W) ? DEP_W : CNT_W;
    localparam int IN_TDATA_W = ((DW + CNT_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);

    // operation codes carried in the request tuser
    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INC  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INC_WR,
        ST_POP_RD,
        ST_POP_FWD,
        ST_EMIT
    } t_state;

endpackage

// ----- hw/rtl/swli_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module swli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/stack_with_lazy_increment.sv -----
// Top level: bounded stack with lazy bottom-k increment, two RAMs and a sequencer.
//
//  channel   dir  handshake                       payload
//  --------  ---  ------------------------------  --------------------------------------
//  s_axis    in   s_axis_tvalid / s_axis_tready   tuser: mode; tdata: value, count
//  m_axis    out  m_axis_tvalid / m_axis_tready   tuser: was_empty; tdata: popped_value
//  cfg       in   i_cfg_valid / o_cfg_ready       i_cfg_data: capacity
//
// Push, no-op and an increment clipped to zero stay in ST_IDLE; increment visits
// ST_INC_WR; pop on empty, ST_EMIT; pop, ST_POP_RD, ST_POP_FWD (not for the bottom
// entry), ST_EMIT, as the pending-add RAM has one read port: pop reads the top slot,
// then the slot below, writes it back. Reset (synchronous, active low) clears depth,
// sequencer and output valid; capacity returns to 1024. No clearing pass: each push
// writes a zero pending slot for the new entry, so a slot is always written before
// it is read. A result waiting in the output register does not block requests; only a
// pop that finishes while the register is still full waits in ST_EMIT.
module stack_with_lazy_increment (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request: tuser = mode[1:0]
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata = value[31:0], count[42:32], zero pad[47:43]
    input  logic [swli_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic [swli_pkg::MODE_W-1:0]        s_axis_tuser,
    // result: tdata = popped_value[31:0]
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [swli_pkg::DW-1:0]            m_axis_tdata,
    // tuser = was_empty
    output logic                               m_axis_tuser,
    // capacity register write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [swli_pkg::CNT_W-1:0]         i_cfg_data
);

    localparam int AW    = swli_pkg::AW;
    localparam int DW    = swli_pkg::DW;
    localparam int DEP_W = swli_pkg::DEP_W;
    localparam int CNT_W = swli_pkg::CNT_W;
    localparam int CMP_W = swli_pkg::CMP_W;

    // control state
    swli_pkg::t_state  r_state, n_state;
    logic [DEP_W-1:0]  r_depth, n_depth;
    logic [CNT_W-1:0]  r_cap;
    logic              r_out_valid, n_out_valid;

    // payload
    logic [AW-1:0]     r_addr, n_addr;     // slot in flight
    logic [DW-1:0]     r_val, n_val;       // increment amount, or the popped slot's add
    logic [DW-1:0]     r_sum, n_sum;       // pop result
    logic              r_empty, n_empty;
    logic [DW-1:0]     r_out_data, n_out_data;
    logic              r_out_empty, n_out_empty;

    // RAM ports
    logic              e_we, e_re;
    logic [AW-1:0]     e_waddr, e_raddr;
    logic [DW-1:0]     e_wdata, e_rdata;
    logic              p_we, p_re;
    logic [AW-1:0]     p_waddr, p_raddr;
    logic [DW-1:0]     p_wdata, p_rdata;

    // request decode
    logic                        in_acc;
    logic [swli_pkg::MODE_W-1:0] in_mode;
    logic [DW-1:0]               in_value;
    logic [CNT_W-1:0]            in_count;
    logic [CMP_W-1:0]            depth_x, cap_x, count_x, clip_k;
    logic                        can_push;

    assign in_mode  = s_axis_tuser;
    assign in_value = s_axis_tdata[DW-1:0];
    assign in_count = s_axis_tdata[DW+CNT_W-1:DW];

    assign s_axis_tready = (r_state == swli_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign depth_x  = CMP_W'(r_depth);
    assign cap_x    = CMP_W'(r_cap);
    assign count_x  = CMP_W'(in_count);
    assign clip_k   = (count_x < depth_x) ? count_x : depth_x;
    // effective capacity is min(capacity, DEPTH)
    assign can_push = (depth_x < cap_x) && (r_depth < DEP_W'(swli_pkg::DEPTH));

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swli_pkg::ST_IDLE;
            r_depth     <= '0;
            r_cap       <= swli_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_val       <= n_val;
        r_sum       <= n_sum;
        r_empty     <= n_empty;
        r_out_data  <= n_out_data;
        r_out_empty <= n_out_empty;
    end

    always_comb begin
        n_state     = r_state;
        n_depth     = r_depth;
        n_addr      = r_addr;
        n_val       = r_val;
        n_sum       = r_sum;
        n_empty     = r_empty;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_empty = r_out_empty;

        e_we    = 1'b0;
        e_waddr = r_depth[AW-1:0];
        e_wdata = in_value;
        e_re    = 1'b0;
        e_raddr = r_addr;
        p_we    = 1'b0;
        p_waddr = r_addr;
        p_wdata = p_rdata + r_val;
        p_re    = 1'b0;
        p_raddr = r_addr;

        case (r_state)
            swli_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (in_mode)
                        swli_pkg::MODE_PUSH: begin
                            if (can_push) begin
                                // new entry starts with an empty pending slot
                                e_we    = 1'b1;
                                p_we    = 1'b1;
                                p_waddr = r_depth[AW-1:0];
                                p_wdata = '0;
                                n_depth = r_depth + DEP_W'(1);
                            end
                        end
                        swli_pkg::MODE_POP: begin
                            if (r_depth == '0) begin
                                n_sum   = '1;
                                n_empty = 1'b1;
                                n_state = swli_pkg::ST_EMIT;
                            end else begin
                                n_addr  = AW'(r_depth - DEP_W'(1));
                                e_re    = 1'b1;
                                e_raddr = n_addr;
                                p_re    = 1'b1;
                                p_raddr = n_addr;
                                n_depth = r_depth - DEP_W'(1);
                                n_empty = 1'b0;
                                n_state = swli_pkg::ST_POP_RD;
                            end
                        end
                        swli_pkg::MODE_INC: begin
                            if (clip_k != '0) begin
                                n_addr  = AW'(clip_k - CMP_W'(1));
                                n_val   = in_value;
                                p_re    = 1'b1;
                                p_raddr = n_addr;
                                n_state = swli_pkg::ST_INC_WR;
                            end
                        end
                        default: begin
                            // no-op code
                        end
                    endcase
                end
            end
            swli_pkg::ST_INC_WR: begin
                p_we    = 1'b1;
                n_state = swli_pkg::ST_IDLE;
            end
            swli_pkg::ST_POP_RD: begin
                n_sum = e_rdata + p_rdata;
                n_val = p_rdata;
                if (r_addr != '0) begin
                    // hand the add down to the slot below
                    n_addr  = r_addr - AW'(1);
                    p_re    = 1'b1;
                    p_raddr = n_addr;
                    n_state = swli_pkg::ST_POP_FWD;
                end else begin
                    n_state = swli_pkg::ST_EMIT;
                end
            end
            swli_pkg::ST_POP_FWD: begin
                p_we    = 1'b1;
                n_state = swli_pkg::ST_EMIT;
            end
            swli_pkg::ST_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_sum;
                    n_out_empty = r_empty;
                    n_state     = swli_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swli_pkg::ST_IDLE;
            end
        endcase
    end

    swli_ram #(
        .WIDTH (DW),
        .DEPTH (swli_pkg::DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_re    (e_re),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    swli_ram #(
        .WIDTH (DW),
        .DEPTH (swli_pkg::DEPTH)
    ) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_re    (p_re),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_empty;

endmodule

// ----- hw/rtl/swli_chk.sv -----
// Port-level checker for the lazy-increment stack, bound to the top level.
module swli_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [swli_pkg::MODE_W-1:0]     s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [swli_pkg::DW-1:0]         m_axis_tdata,
    input logic                            m_axis_tuser
);

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // an empty pop always reports -1
    a_empty_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '1))
        else $error("empty pop without -1");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    // a push never produces a result
    a_push_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == swli_pkg::MODE_PUSH)
         && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result after push");

    // an accepted pop takes the sequencer out of ST_IDLE, which drops s_axis_tready
    a_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == swli_pkg::MODE_POP))
        |=> !s_axis_tready)
        else $error("request taken right after pop");

endmodule

bind stack_with_lazy_increment swli_chk u_swli_chk (.*);
